@@ hdl/simap_pkg.sv @@
// shared types and constants for the segmented index mapper
package simap_pkg;

  localparam int IDX_W   = 32;
  localparam int CNT_W   = 32;
  localparam int DIM_W   = 16;
  localparam int SEGNO_W = 4;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // one stored segment
  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } seg_t;

  // lookup request travelling down the cell chain
  typedef struct packed {
    logic               vld;
    logic               done;
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [SEGNO_W-1:0] segno;
    logic [IDX_W-1:0]   offset;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APP_A,
    ST_APP_B,
    ST_LOOK
  } state_t;

endpackage

@@ hdl/segmented_index_mapper.sv @@
// top level: ordered segment table with append and index lookup over a chain of cells
// append: passes through ST_APP_A and ST_APP_B, busy in both; the result strobe is registered from ST_APP_B
// lookup: result strobe registered from the last cell's output; the request walks one cell a cycle
// one request at a time; busy falls in the strobe cycle, so a new request can start then
// results cannot be stalled: out_valid marks each result for exactly one cycle
// synchronous active-low reset empties the table and clears the flags; slots need no clearing
module segmented_index_mapper
  import simap_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [IDX_W-1:0]   in_global_index,
  input  logic [IDX_W-1:0]   in_requested_start,
  input  logic [CNT_W-1:0]   in_frame_count,
  input  logic [DIM_W-1:0]   in_sub_width,
  input  logic [DIM_W-1:0]   in_sub_height,
  output logic               out_valid,
  output logic               out_ok,
  output logic [SEGNO_W-1:0] out_segment_number,
  output logic [IDX_W-1:0]   out_frame_offset,
  output logic [IDX_W-1:0]   out_granted_start,
  output logic [DIM_W-1:0]   out_found_width,
  output logic [DIM_W-1:0]   out_found_height,
  output logic               out_gaps_flag,
  output logic               out_uniform_size_flag
);

  // fill count wide enough to hold the table depth itself
  localparam int UW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [UW-1:0] FULL = UW'(MAX_SEGMENTS);

  state_t state_r, state_nxt;

  logic accept;
  assign accept = start && (state_r == ST_IDLE);

  // captured request
  logic [IDX_W-1:0] req_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIM_W-1:0] w_r, h_r;

  // table bookkeeping
  logic [UW-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0] total_r, total_nxt;
  logic             gaps_r, gaps_nxt;
  logic             same_r, same_nxt;
  logic [IDX_W-1:0] last_start_r, last_start_nxt;
  logic [CNT_W-1:0] last_cnt_r, last_cnt_nxt;
  logic [DIM_W-1:0] last_w_r, last_w_nxt, last_h_r, last_h_nxt;

  // append pipeline registers
  logic [IDX_W-1:0] s1_r, s1_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic             rej_r, rej_nxt;

  // result registers
  logic               ov_r, ov_nxt;
  logic               ok_r, ok_nxt;
  logic [SEGNO_W-1:0] segno_r, segno_nxt;
  logic [IDX_W-1:0]   off_r, off_nxt;
  logic [IDX_W-1:0]   gnt_r, gnt_nxt;
  logic [DIM_W-1:0]   fw_r, fw_nxt, fh_r, fh_nxt;

  // cell chain
  tok_t tok [MAX_SEGMENTS+1];
  logic wr_en;
  seg_t wr_seg;
  logic [IDX_W-1:0] grant;

  // lookup request enters the head of the chain on accept
  always_comb begin
    tok[0]     = '0;
    tok[0].vld = accept && (in_command == CMD_LOOKUP);
    tok[0].idx = in_global_index;
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
      simap_cell #(
        .IDX (gi),
        .UW  (UW)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .used_i   (used_r),
        .wr_en_i  (wr_en),
        .wr_sel_i (used_r),
        .wr_seg_i (wr_seg),
        .tok_i    (tok[gi]),
        .tok_o    (tok[gi+1])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == CMD_LOOKUP) ? ST_LOOK : ST_APP_A;
        end
      end
      ST_APP_A: state_nxt = ST_APP_B;
      ST_APP_B: state_nxt = ST_IDLE;
      ST_LOOK: begin
        if (tok[MAX_SEGMENTS].vld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result values
  always_comb begin
    used_nxt       = used_r;
    total_nxt      = total_r;
    gaps_nxt       = gaps_r;
    same_nxt       = same_r;
    last_start_nxt = last_start_r;
    last_cnt_nxt   = last_cnt_r;
    last_w_nxt     = last_w_r;
    last_h_nxt     = last_h_r;
    s1_nxt         = s1_r;
    end_nxt        = end_r;
    rej_nxt        = rej_r;
    ov_nxt         = 1'b0;
    ok_nxt         = ok_r;
    segno_nxt      = segno_r;
    off_nxt        = off_r;
    gnt_nxt        = gnt_r;
    fw_nxt         = fw_r;
    fh_nxt         = fh_r;
    wr_en          = 1'b0;
    grant          = s1_r;
    wr_seg.start   = grant;
    wr_seg.count   = cnt_r;
    wr_seg.width   = w_r;
    wr_seg.height  = h_r;

    case (state_r)
      ST_APP_A: begin
        // raise to the running total, and form the end of the last segment
        s1_nxt  = (req_r < total_r) ? total_r : req_r;
        end_nxt = last_start_r + last_cnt_r;
        rej_nxt = (cnt_r == '0) || (used_r >= FULL);
      end
      ST_APP_B: begin
        if (used_r != '0 && s1_r < end_r) begin
          grant = end_r;
        end
        wr_seg.start = grant;
        ov_nxt    = 1'b1;
        segno_nxt = '0;
        off_nxt   = '0;
        fw_nxt    = '0;
        fh_nxt    = '0;
        if (rej_r) begin
          ok_nxt  = 1'b0;
          gnt_nxt = '0;
        end else begin
          ok_nxt         = 1'b1;
          gnt_nxt        = grant;
          wr_en          = 1'b1;
          used_nxt       = used_r + 1'b1;
          total_nxt      = total_r + cnt_r;
          last_start_nxt = grant;
          last_cnt_nxt   = cnt_r;
          last_w_nxt     = w_r;
          last_h_nxt     = h_r;
          if (used_r == '0) begin
            // first segment sets the size reference
            same_nxt = 1'b1;
            if (grant != '0) begin
              gaps_nxt = 1'b1;
            end
          end else begin
            if (w_r != last_w_r || h_r != last_h_r) begin
              same_nxt = 1'b0;
            end
            if (grant > end_r) begin
              gaps_nxt = 1'b1;
            end
          end
        end
      end
      ST_LOOK: begin
        if (tok[MAX_SEGMENTS].vld) begin
          ov_nxt    = 1'b1;
          ok_nxt    = tok[MAX_SEGMENTS].hit;
          segno_nxt = tok[MAX_SEGMENTS].segno;
          off_nxt   = tok[MAX_SEGMENTS].offset;
          fw_nxt    = tok[MAX_SEGMENTS].width;
          fh_nxt    = tok[MAX_SEGMENTS].height;
          gnt_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      total_r <= '0;
      gaps_r  <= 1'b0;
      same_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
      gaps_r  <= gaps_nxt;
      same_r  <= same_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_requested_start;
      cnt_r <= in_frame_count;
      w_r   <= in_sub_width;
      h_r   <= in_sub_height;
    end
    last_start_r <= last_start_nxt;
    last_cnt_r   <= last_cnt_nxt;
    last_w_r     <= last_w_nxt;
    last_h_r     <= last_h_nxt;
    s1_r         <= s1_nxt;
    end_r        <= end_nxt;
    rej_r        <= rej_nxt;
    ok_r         <= ok_nxt;
    segno_r      <= segno_nxt;
    off_r        <= off_nxt;
    gnt_r        <= gnt_nxt;
    fw_r         <= fw_nxt;
    fh_r         <= fh_nxt;
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = ov_r;
  assign out_ok                = ok_r;
  assign out_segment_number    = segno_r;
  assign out_frame_offset      = off_r;
  assign out_granted_start     = gnt_r;
  assign out_found_width       = fw_r;
  assign out_found_height      = fh_r;
  assign out_gaps_flag         = gaps_r;
  assign out_uniform_size_flag = same_r;

endmodule

@@ hdl/simap_cell.sv @@
// one table slot: holds a segment and checks a passing lookup request against it
module simap_cell
  import simap_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int UW   = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [UW-1:0] used_i,
  input  logic          wr_en_i,
  input  logic [UW-1:0] wr_sel_i,
  input  seg_t          wr_seg_i,
  input  tok_t          tok_i,
  output tok_t          tok_o
);

  localparam logic [UW-1:0]      MY_SEL   = UW'(IDX);
  localparam logic [SEGNO_W-1:0] MY_SEGNO = SEGNO_W'(IDX);

  seg_t seg_r;
  tok_t tok_r, tok_nxt;

  logic             active;
  logic [IDX_W-1:0] off;

  always_comb begin
    active  = (MY_SEL < used_i);
    off     = tok_i.idx - seg_r.start;
    tok_nxt = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (!active) begin
        tok_nxt.done = 1'b1;
      end else if (tok_i.idx < seg_r.start) begin
        // walk stops at first segment starting past the index
        tok_nxt.done = 1'b1;
      end else if (off < seg_r.count) begin
        tok_nxt.done   = 1'b1;
        tok_nxt.hit    = 1'b1;
        tok_nxt.segno  = MY_SEGNO;
        tok_nxt.offset = off;
        tok_nxt.width  = seg_r.width;
        tok_nxt.height = seg_r.height;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_i && (wr_sel_i == MY_SEL)) begin
      seg_r <= wr_seg_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ tb/segmented_index_mapper_test.sv @@
// self-checking testbench for segmented_index_mapper: directed table plus random requests
`timescale 1ns / 100ps

module segmented_index_mapper_test;
  import simap_pkg::*;

  localparam int SEG_SLOTS      = 16;
  localparam int RANDOM_ITEMS   = 1533;
  localparam int DRAIN_CYCLES   = SEG_SLOTS + 4;   // lookup latency plus margin
  localparam int WATCHDOG_LIMIT = 1000;

  // one request as the block sees it
  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   global_index;
    logic [IDX_W-1:0]   requested_start;
    logic [CNT_W-1:0]   frame_count;
    logic [DIM_W-1:0]   sub_width;
    logic [DIM_W-1:0]   sub_height;
  } mapper_req_t;

  // one result as the block returns it
  typedef struct packed {
    logic               ok;
    logic [SEGNO_W-1:0] segment_number;
    logic [IDX_W-1:0]   frame_offset;
    logic [IDX_W-1:0]   granted_start;
    logic [DIM_W-1:0]   found_width;
    logic [DIM_W-1:0]   found_height;
    logic               gaps_flag;
    logic               uniform_size_flag;
  } mapper_res_t;

  // directed row: typed rows carry a hand-written result, the rest use the table model
  typedef struct packed {
    bit          typed;
    mapper_req_t q;
    mapper_res_t e;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_command = CMD_LOOKUP;
  logic [IDX_W-1:0]   in_global_index = '0;
  logic [IDX_W-1:0]   in_requested_start = '0;
  logic [CNT_W-1:0]   in_frame_count = '0;
  logic [DIM_W-1:0]   in_sub_width = '0;
  logic [DIM_W-1:0]   in_sub_height = '0;
  logic               out_valid;
  logic               out_ok;
  logic [SEGNO_W-1:0] out_segment_number;
  logic [IDX_W-1:0]   out_frame_offset;
  logic [IDX_W-1:0]   out_granted_start;
  logic [DIM_W-1:0]   out_found_width;
  logic [DIM_W-1:0]   out_found_height;
  logic               out_gaps_flag;
  logic               out_uniform_size_flag;

  // shadow copy of the segment table
  logic [IDX_W-1:0] tbl_start  [SEG_SLOTS];
  logic [CNT_W-1:0] tbl_count  [SEG_SLOTS];
  logic [DIM_W-1:0] tbl_width  [SEG_SLOTS];
  logic [DIM_W-1:0] tbl_height [SEG_SLOTS];
  int               tbl_used = 0;
  logic [CNT_W-1:0] tbl_total = '0;
  logic             tbl_gaps = 1'b0;
  logic             tbl_uniform = 1'b0;

  mapper_res_t   pending_maps[$];
  directed_row_t script[$];
  mapper_res_t   seen, wanted;
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            no_idle = 1'b0;

  segmented_index_mapper #(
    .MAX_SEGMENTS(SEG_SLOTS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_global_index      (in_global_index),
    .in_requested_start   (in_requested_start),
    .in_frame_count       (in_frame_count),
    .in_sub_width         (in_sub_width),
    .in_sub_height        (in_sub_height),
    .out_valid            (out_valid),
    .out_ok               (out_ok),
    .out_segment_number   (out_segment_number),
    .out_frame_offset     (out_frame_offset),
    .out_granted_start    (out_granted_start),
    .out_found_width      (out_found_width),
    .out_found_height     (out_found_height),
    .out_gaps_flag        (out_gaps_flag),
    .out_uniform_size_flag(out_uniform_size_flag)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // applies one request to the shadow table and returns the result it should produce
  function automatic mapper_res_t table_apply(mapper_req_t q);
    mapper_res_t      res;
    logic [IDX_W-1:0] pos, last_end, off;
    int               i;
    bit               done;
    res = '0;
    done = 1'b0;
    if (q.command == CMD_APPEND) begin
      // zero count or full table: nothing stored, ok stays low
      if (q.frame_count != 0 && tbl_used < SEG_SLOTS) begin
        pos = q.requested_start;
        if (pos < tbl_total) pos = tbl_total;
        if (tbl_used == 0) begin
          // first segment sets the size reference; a nonzero start is a gap
          tbl_uniform = 1'b1;
          if (pos != 0) tbl_gaps = 1'b1;
        end else begin
          // end of the last segment wraps modulo 2^32
          last_end = tbl_start[tbl_used-1] + tbl_count[tbl_used-1];
          if (q.sub_width != tbl_width[tbl_used-1] || q.sub_height != tbl_height[tbl_used-1])
            tbl_uniform = 1'b0;
          if (pos < last_end) pos = last_end;
          if (pos > last_end) tbl_gaps = 1'b1;
        end
        tbl_total = tbl_total + q.frame_count;
        tbl_start[tbl_used]  = pos;
        tbl_count[tbl_used]  = q.frame_count;
        tbl_width[tbl_used]  = q.sub_width;
        tbl_height[tbl_used] = q.sub_height;
        tbl_used++;
        res.ok = 1'b1;
        res.granted_start = pos;
      end
    end else begin
      // walk in order; stop at the first hit or at the first start past the index
      for (i = 0; i < tbl_used && !done; i++) begin
        if (q.global_index < tbl_start[i]) begin
          done = 1'b1;
        end else begin
          off = q.global_index - tbl_start[i];
          if (off < tbl_count[i]) begin
            done = 1'b1;
            res.ok = 1'b1;
            res.segment_number = i[SEGNO_W-1:0];
            res.frame_offset = off;
            res.found_width = tbl_width[i];
            res.found_height = tbl_height[i];
          end
        end
      end
    end
    res.gaps_flag = tbl_gaps;
    res.uniform_size_flag = tbl_uniform;
    return res;
  endfunction

  function automatic mapper_req_t mk_req(logic cmd, logic [31:0] idx, logic [31:0] req,
                                         logic [31:0] cnt, logic [15:0] w, logic [15:0] h);
    return {cmd, idx, req, cnt, w, h};
  endfunction

  function automatic mapper_res_t mk_res(logic ok, logic [3:0] segno, logic [31:0] off,
                                         logic [31:0] granted, logic [15:0] w, logic [15:0] h,
                                         logic gaps, logic uni);
    return {ok, segno, off, granted, w, h, gaps, uni};
  endfunction

  function automatic directed_row_t row(bit typed, mapper_req_t q, mapper_res_t e);
    return {typed, q, e};
  endfunction

  // appends one row to the directed table
  task automatic add_row(directed_row_t r);
    script = {script, r};
  endtask

  // random request shaped by the current table: mostly lookups aimed at stored segments,
  // appends spread out until the table is full, and some noise
  function automatic mapper_req_t random_request(int left);
    mapper_req_t r;
    int          k;
    logic [63:0] span, pick;
    r.command         = CMD_LOOKUP;
    r.global_index    = $urandom;
    r.requested_start = $urandom;
    r.frame_count     = $urandom;
    r.sub_width       = 16'($urandom);
    r.sub_height      = 16'($urandom);
    if (tbl_used < SEG_SLOTS &&
        ($urandom_range(0, 99) == 0 || left <= (SEG_SLOTS - tbl_used) * 30)) begin
      r.command = CMD_APPEND;
      case ($urandom_range(0, 3))
        0: r.requested_start = '0;
        1: r.requested_start = tbl_total + $urandom_range(0, 8);
        default: r.requested_start = $urandom_range(0, 300);
      endcase
      // the second-to-last slot gets a huge count so the running total and end wrap
      if (tbl_used == SEG_SLOTS - 2)
        r.frame_count = {24'hFF_FFFF, 8'($urandom)};
      else
        r.frame_count = $urandom_range(1, 40);
      if ($urandom_range(0, 1) == 1) begin
        r.sub_width  = 16'd16;
        r.sub_height = 16'd16;
      end
    end else if ($urandom_range(0, 99) < 8) begin
      // noise append: all fields random once full, zero count before that
      r.command = CMD_APPEND;
      if (tbl_used < SEG_SLOTS) r.frame_count = '0;
    end else if ($urandom_range(0, 9) < 7 && tbl_used != 0) begin
      // aim at a stored segment, one past each edge included
      k = $urandom_range(0, tbl_used - 1);
      span = {32'b0, tbl_count[k]} + 64'd2;
      pick = {$urandom, $urandom} % span;
      r.global_index = tbl_start[k] + pick[31:0] - 32'd1;
    end
    return r;
  endfunction

  // drives one request and waits until the block takes it
  task automatic send_request(mapper_req_t q, bit typed, mapper_res_t e);
    int          gap;
    mapper_res_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_command         <= q.command;
    in_global_index    <= q.global_index;
    in_requested_start <= q.requested_start;
    in_frame_count     <= q.frame_count;
    in_sub_width       <= q.sub_width;
    in_sub_height      <= q.sub_height;
    // request taken at the edge where start is high and busy low
    do @(posedge clk); while (busy);
    predicted = table_apply(q);
    pending_maps = {pending_maps, (typed ? e : predicted)};
  endtask

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen = {out_ok, out_segment_number, out_frame_offset, out_granted_start,
              out_found_width, out_found_height, out_gaps_flag, out_uniform_size_flag};
      if (pending_maps.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %0h", $time, seen);
        mismatches++;
      end else begin
        wanted = pending_maps.pop_front();
        check_field("ok", 32'(wanted.ok), 32'(seen.ok));
        check_field("segment_number", 32'(wanted.segment_number),
                    32'(seen.segment_number));
        check_field("frame_offset", wanted.frame_offset, seen.frame_offset);
        check_field("granted_start", wanted.granted_start, seen.granted_start);
        check_field("found_width", 32'(wanted.found_width), 32'(seen.found_width));
        check_field("found_height", 32'(wanted.found_height), 32'(seen.found_height));
        check_field("gaps_flag", 32'(wanted.gaps_flag), 32'(seen.gaps_flag));
        check_field("uniform_size_flag", 32'(wanted.uniform_size_flag),
                    32'(seen.uniform_size_flag));
      end
    end
  end

  // watchdog: too long with neither a request taken nor a result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
        $display("segmented_index_mapper regression: fail");
        $finish;
      end
    end
  end

  initial begin
    // directed table: empty table, zero count, first segment, raised start, gap,
    // walk stop, size and count change, index extremes
    add_row(row(1, mk_req(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0),
                mk_res(0, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(1, mk_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0),
                mk_res(0, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(1, mk_req(CMD_APPEND, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF),
                mk_res(0, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(1, mk_req(CMD_APPEND, 32'h0, 32'h0, 32'd4, 16'd16, 16'd16),
                mk_res(1, 0, 0, 0, 0, 0, 0, 1)));
    add_row(row(1, mk_req(CMD_LOOKUP, 32'd0, 32'h0, 32'h0, 16'h0, 16'h0),
                mk_res(1, 0, 0, 0, 16'd16, 16'd16, 0, 1)));
    add_row(row(1, mk_req(CMD_LOOKUP, 32'd3, 32'h0, 32'h0, 16'h0, 16'h0),
                mk_res(1, 0, 32'd3, 0, 16'd16, 16'd16, 0, 1)));
    add_row(row(1, mk_req(CMD_LOOKUP, 32'd4, 32'h0, 32'h0, 16'h0, 16'h0),
                mk_res(0, 0, 0, 0, 0, 0, 0, 1)));
    add_row(row(1, mk_req(CMD_APPEND, 32'h0, 32'h0, 32'd4, 16'd16, 16'd16),
                mk_res(1, 0, 0, 32'd4, 0, 0, 0, 1)));
    add_row(row(0, mk_req(CMD_APPEND, 32'h0, 32'd20, 32'd4, 16'd16, 16'd16), '0));
    add_row(row(0, mk_req(CMD_LOOKUP, 32'd10, 32'h0, 32'h0, 16'h0, 16'h0), '0));
    add_row(row(0, mk_req(CMD_LOOKUP, 32'd21, 32'h0, 32'h0, 16'h0, 16'h0), '0));
    add_row(row(0, mk_req(CMD_APPEND, 32'h0, 32'h0, 32'd7, 16'h0, 16'h0), '0));
    add_row(row(0, mk_req(CMD_LOOKUP, 32'd30, 32'h0, 32'h0, 16'h0, 16'h0), '0));
    add_row(row(0, mk_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0), '0));
    add_row(row(0, mk_req(CMD_APPEND, 32'h0, 32'd31, 32'd3, 16'hFFFF, 16'hFFFF), '0));
    add_row(row(0, mk_req(CMD_LOOKUP, 32'd33, 32'h0, 32'h0, 16'h0, 16'h0), '0));
    add_row(row(0, mk_req(CMD_LOOKUP, 32'd7, 32'h0, 32'h0, 16'h0, 16'h0), '0));

    // reset held from time zero, then released for good
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[n]) send_request(script[n].q, script[n].typed, script[n].e);

    // random requests, with occasional runs of back-to-back requests
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      send_request(random_request(RANDOM_ITEMS - n), 1'b0, '0);
    end
    start <= 1'b0;

    // drain: wait for the last results, then a lookup's latency for strays
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("segmented_index_mapper regression: pass");
    end else begin
      $display("segmented_index_mapper regression: fail");
    end
    $finish;
  end

endmodule
